[rtl/gmp_pkg.sv]
package gmp_pkg;

  // Input item codes
  localparam logic FUNC_TRIANGLE = 1'b0;
  localparam logic FUNC_FLUSH    = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_MAX_VERTICES      = 2'd0;
  localparam logic [1:0] CFG_MAX_TRIANGLES     = 2'd1;
  localparam logic [1:0] CFG_MESH_VERTEX_COUNT = 2'd2;

  // Configuration reset values
  localparam logic [6:0]  MAX_VERTICES_RST      = 7'd64;
  localparam logic [7:0]  MAX_TRIANGLES_RST     = 8'd124;
  localparam logic [31:0] MESH_VERTEX_COUNT_RST = 32'd0;

  // Depth of the command queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Result record kinds
  typedef enum logic [1:0] {
    KIND_VERTEX     = 2'd0,
    KIND_TRIANGLE   = 2'd1,
    KIND_DESCRIPTOR = 2'd2
  } kind_t;

  typedef struct packed {
    logic [6:0]  max_vertices;
    logic [7:0]  max_triangles;
    logic [31:0] mesh_vertex_count;
  } cfg_t;

  // One resolved request: optional descriptor, new vertices, optional triangle
  typedef struct packed {
    logic             close;
    logic [31:0]      desc_voff;
    logic [6:0]       desc_vcnt;
    logic [31:0]      desc_toff;
    logic [7:0]       desc_tcnt;
    logic             emit_tri;
    logic [2:0]       vnew;
    logic [2:0][31:0] vidx;
    logic [23:0]      packed_tri;
  } cmd_t;

endpackage

[rtl/gmp_front.sv]
module gmp_front #(
  parameter int TABLE_SLOTS = 64,
  parameter int INDEX_BITS  = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  gmp_pkg::cfg_t cfg,
  input  logic          in_push,
  output logic          in_full,
  input  logic          in_func,
  input  logic [31:0]   in_first_index,
  input  logic [31:0]   in_second_index,
  input  logic [31:0]   in_third_index,
  input  logic          q_full,
  output logic          q_push,
  output gmp_pkg::cmd_t q_cmd
);
  import gmp_pkg::*;

  localparam int CW = $clog2(TABLE_SLOTS + 1);
  localparam int SW = $clog2(TABLE_SLOTS);
  localparam int XW = ((CW > 7) ? CW : 7) + 1;

  // Local vertex table (CAM), valid below the fill count
  logic [INDEX_BITS-1:0] tab_r [TABLE_SLOTS];

  // Open meshlet state
  logic [CW-1:0] count_r;
  logic [7:0]    tri_r;
  logic [31:0]   vbase_r;
  logic [31:0]   tbase_r;

  // Vertices added by the most recent resolve, forwarded to the next lookup
  logic [2:0]            rec_new_r;
  logic [INDEX_BITS-1:0] rec_idx_r  [3];
  logic [SW-1:0]         rec_slot_r [3];
  logic [CW-1:0]         rec_base_r;

  // Stage register: captured request plus raw table match vectors
  logic                   s1_valid_r;
  logic                   s1_func_r;
  logic                   s1_bad_r;
  logic [INDEX_BITS-1:0]  s1_idx_r   [3];
  logic [TABLE_SLOTS-1:0] s1_match_r [3];

  logic                   accept;
  logic                   advance;
  logic [INDEX_BITS-1:0]  acc_idx   [3];
  logic [TABLE_SLOTS-1:0] acc_match [3];
  logic                   acc_bad;

  logic [2:0]     hit_any;
  logic [SW-1:0]  slot_pre [3];
  logic [XW-1:0]  missing;
  logic [XW-1:0]  vtot;
  logic [XW-1:0]  limit;
  logic           is_tri;
  logic           is_flush;
  logic           close;
  logic [2:0]     found;
  logic [CW-1:0]  base;
  logic [2:0]     new_v;
  logic [SW-1:0]  slot [3];
  logic [CW-1:0]  add_cnt;
  logic [CW-1:0]  count_nxt;
  logic [7:0]     tri_nxt;

  assign in_full = s1_valid_r & q_full;
  assign accept  = in_push & ~in_full;
  assign advance = s1_valid_r & ~q_full;

  assign acc_idx[0] = in_first_index[INDEX_BITS-1:0];
  assign acc_idx[1] = in_second_index[INDEX_BITS-1:0];
  assign acc_idx[2] = in_third_index[INDEX_BITS-1:0];

  // Accept side: range check and parallel compare against every table entry
  always_comb begin
    int i;
    int l;
    acc_bad = 1'b0;
    for (l = 0; l < 3; l++) begin
      if (32'(acc_idx[l]) >= cfg.mesh_vertex_count) acc_bad = 1'b1;
      for (i = 0; i < TABLE_SLOTS; i++) begin
        acc_match[l][i] = (tab_r[i] == acc_idx[l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func_r <= in_func;
      s1_bad_r  <= acc_bad;
      for (int l = 0; l < 3; l++) begin
        s1_idx_r[l]   <= acc_idx[l];
        s1_match_r[l] <= acc_match[l];
      end
    end
  end

  // Lookup: entries older than the last resolve, plus that resolve's additions
  always_comb begin
    int i;
    int j;
    int l;
    for (l = 0; l < 3; l++) begin
      hit_any[l]  = 1'b0;
      slot_pre[l] = '0;
      for (i = 0; i < TABLE_SLOTS; i++) begin
        if (s1_match_r[l][i] && (CW'(i) < rec_base_r)) begin
          hit_any[l]  = 1'b1;
          slot_pre[l] = slot_pre[l] | SW'(i);
        end
      end
      for (j = 0; j < 3; j++) begin
        if (rec_new_r[j] && (s1_idx_r[l] == rec_idx_r[j])) begin
          hit_any[l]  = 1'b1;
          slot_pre[l] = slot_pre[l] | rec_slot_r[j];
        end
      end
    end
  end

  // Classify: overflow test counts every missing corner
  always_comb begin
    missing  = XW'(!hit_any[0]) + XW'(!hit_any[1]) + XW'(!hit_any[2]);
    vtot     = XW'(count_r) + missing;
    limit    = (XW'(cfg.max_vertices) < XW'(TABLE_SLOTS)) ? XW'(cfg.max_vertices)
                                                          : XW'(TABLE_SLOTS);
    is_tri   = (s1_func_r == FUNC_TRIANGLE) && !s1_bad_r;
    is_flush = (s1_func_r == FUNC_FLUSH);
    close    = (tri_r != 8'd0) &&
               (is_flush || (is_tri && ((vtot > limit) || (tri_r >= cfg.max_triangles))));
  end

  // Slot assignment; a closed meshlet starts from an empty table
  always_comb begin
    base  = close ? '0 : count_r;
    found = hit_any & {3{~close}};

    new_v[0] = ~found[0];
    slot[0]  = found[0] ? slot_pre[0] : SW'(base);

    if (found[1]) begin
      new_v[1] = 1'b0;
      slot[1]  = slot_pre[1];
    end else if (new_v[0] && (s1_idx_r[1] == s1_idx_r[0])) begin
      new_v[1] = 1'b0;
      slot[1]  = slot[0];
    end else begin
      new_v[1] = 1'b1;
      slot[1]  = SW'(base) + SW'(new_v[0]);
    end

    if (found[2]) begin
      new_v[2] = 1'b0;
      slot[2]  = slot_pre[2];
    end else if (new_v[0] && (s1_idx_r[2] == s1_idx_r[0])) begin
      new_v[2] = 1'b0;
      slot[2]  = slot[0];
    end else if (new_v[1] && (s1_idx_r[2] == s1_idx_r[1])) begin
      new_v[2] = 1'b0;
      slot[2]  = slot[1];
    end else begin
      new_v[2] = 1'b1;
      slot[2]  = SW'(base) + SW'(new_v[0]) + SW'(new_v[1]);
    end

    add_cnt   = CW'(new_v[0]) + CW'(new_v[1]) + CW'(new_v[2]);
    count_nxt = base + add_cnt;
    tri_nxt   = (close ? 8'd0 : tri_r) + 8'd1;
  end

  // Command toward the back
  assign q_push = advance & (close | is_tri);

  always_comb begin
    q_cmd.close      = close;
    q_cmd.desc_voff  = vbase_r;
    q_cmd.desc_vcnt  = 7'(count_r);
    q_cmd.desc_toff  = tbase_r;
    q_cmd.desc_tcnt  = tri_r;
    q_cmd.emit_tri   = is_tri;
    q_cmd.vnew       = new_v & {3{is_tri}};
    q_cmd.vidx[0]    = 32'(s1_idx_r[0]);
    q_cmd.vidx[1]    = 32'(s1_idx_r[1]);
    q_cmd.vidx[2]    = 32'(s1_idx_r[2]);
    q_cmd.packed_tri = {8'(slot[2]), 8'(slot[1]), 8'(slot[0])};
  end

  // Meshlet state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      tri_r      <= 8'd0;
      vbase_r    <= 32'd0;
      tbase_r    <= 32'd0;
      rec_new_r  <= 3'b000;
      rec_base_r <= '0;
    end else if (advance) begin
      if (close) begin
        vbase_r <= vbase_r + 32'(count_r);
        tbase_r <= tbase_r + 32'(tri_r);
      end
      if (is_tri) begin
        count_r    <= count_nxt;
        tri_r      <= tri_nxt;
        rec_new_r  <= new_v;
        rec_base_r <= base;
      end else if (close) begin
        count_r    <= '0;
        tri_r      <= 8'd0;
        rec_new_r  <= 3'b000;
        rec_base_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && is_tri) begin
      for (int l = 0; l < 3; l++) begin
        rec_idx_r[l]  <= s1_idx_r[l];
        rec_slot_r[l] <= slot[l];
      end
    end
  end

  // Table writes at the new slots
  always_ff @(posedge clk) begin
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      for (int l = 0; l < 3; l++) begin
        if (advance && is_tri && new_v[l] && (slot[l] == SW'(i))) begin
          tab_r[i] <= s1_idx_r[l];
        end
      end
    end
  end

  // Fill count stays within the table
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_SLOTS))
    else $error("fill count beyond table");

  // Forwarded additions sit at or above the stable boundary
  a_rec_base: assert property (@(posedge clk) disable iff (!rst_n)
    rec_base_r <= count_r)
    else $error("forwarding base above fill count");

  // An empty meshlet holds no vertices
  a_empty_meshlet: assert property (@(posedge clk) disable iff (!rst_n)
    (tri_r == 8'd0) |-> (count_r == '0))
    else $error("vertices without triangles");

  // Flush of an open meshlet leaves it empty
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && is_flush && (tri_r != 8'd0)) |=> (tri_r == 8'd0))
    else $error("flush left meshlet open");

endmodule

[rtl/gmp_cmd_queue.sv]
module gmp_cmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  gmp_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output gmp_pkg::cmd_t head_cmd,
  output logic          empty
);
  import gmp_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [NW-1:0] cnt_r;
  logic          do_push;
  logic          do_pop;

  assign full     = (cnt_r == NW'(QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push & ~full;
  assign do_pop   = pop & ~empty;
  assign head_cmd = mem_r[rd_ptr_r];

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + PW'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + PW'(1);
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + NW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_cmd;
  end

endmodule

[rtl/gmp_back.sv]
module gmp_back (
  input  logic          clk,
  input  logic          rst_n,
  input  gmp_pkg::cmd_t head_cmd,
  input  logic          q_empty,
  output logic          q_pop,
  output logic [1:0]    out_kind,
  output logic [31:0]   out_global_vertex,
  output logic [23:0]   out_packed_triangle,
  output logic [31:0]   out_vertex_offset,
  output logic [6:0]    out_vertex_count,
  output logic [31:0]   out_triangle_offset,
  output logic [7:0]    out_triangle_count,
  output logic          out_last,
  output logic          out_empty,
  input  logic          out_pop
);
  import gmp_pkg::*;

  // Result order within one request: descriptor, up to three new vertices, triangle
  localparam int STEP_DESC = 0;
  localparam int STEP_V0   = 1;
  localparam int STEP_V1   = 2;
  localparam int STEP_V2   = 3;
  localparam int STEP_TRI  = 4;
  localparam int NSTEPS    = 5;

  logic [NSTEPS-1:0] done_r;
  logic [NSTEPS-1:0] want;
  logic [NSTEPS-1:0] pend;
  logic [NSTEPS-1:0] sel;
  logic              sel_last;
  logic              emit;
  logic              out_valid_r;

  kind_t       kind_nxt;
  logic [31:0] gv_nxt;

  always_comb begin
    want[STEP_DESC] = head_cmd.close;
    want[STEP_V0]   = head_cmd.vnew[0];
    want[STEP_V1]   = head_cmd.vnew[1];
    want[STEP_V2]   = head_cmd.vnew[2];
    want[STEP_TRI]  = head_cmd.emit_tri;
    pend            = want & ~done_r;
    sel             = pend & (~pend + NSTEPS'(1));
    sel_last        = ((pend & ~sel) == '0);
  end

  assign out_empty = ~out_valid_r;
  assign emit      = ~q_empty & (~out_valid_r | out_pop);
  assign q_pop     = emit & sel_last;

  // Step tracking for the head request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        done_r <= sel_last ? '0 : (done_r | sel);
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Field selection for the chosen step
  always_comb begin
    if (sel[STEP_DESC]) begin
      kind_nxt = KIND_DESCRIPTOR;
    end else if (sel[STEP_TRI]) begin
      kind_nxt = KIND_TRIANGLE;
    end else begin
      kind_nxt = KIND_VERTEX;
    end
    gv_nxt = ({32{sel[STEP_V0]}} & head_cmd.vidx[0]) |
             ({32{sel[STEP_V1]}} & head_cmd.vidx[1]) |
             ({32{sel[STEP_V2]}} & head_cmd.vidx[2]);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind            <= kind_nxt;
      out_global_vertex   <= gv_nxt;
      out_packed_triangle <= sel[STEP_TRI] ? head_cmd.packed_tri : 24'd0;
      out_vertex_offset   <= sel[STEP_DESC] ? head_cmd.desc_voff : 32'd0;
      out_vertex_count    <= sel[STEP_DESC] ? head_cmd.desc_vcnt : 7'd0;
      out_triangle_offset <= sel[STEP_DESC] ? head_cmd.desc_toff : 32'd0;
      out_triangle_count  <= sel[STEP_DESC] ? head_cmd.desc_tcnt : 8'd0;
      out_last            <= sel_last;
    end
  end

endmodule

[rtl/greedy_meshlet_partitioner.sv]
// A request crosses the front stage, queue and output registers. Throughput: the
// front resolves one request per cycle unless the queue is full; the back drains
// one result per cycle while the output is free. A triangle gives 1 to 5 results
// (descriptor, up to 3 vertices, triangle); a dropped triangle or empty flush
// gives none. Reset (rst_n low, synchronous): meshlet counts, offsets, queue and
// output valid clear, config goes to 64/124/0; table entries live by fill count.
module greedy_meshlet_partitioner #(
  parameter int TABLE_SLOTS = 64,
  parameter int INDEX_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_func,
  input  logic [31:0] in_first_index,
  input  logic [31:0] in_second_index,
  input  logic [31:0] in_third_index,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_kind,
  output logic [31:0] out_global_vertex,
  output logic [23:0] out_packed_triangle,
  output logic [31:0] out_vertex_offset,
  output logic [6:0]  out_vertex_count,
  output logic [31:0] out_triangle_offset,
  output logic [7:0]  out_triangle_count,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import gmp_pkg::*;

  cfg_t cfg_r;
  logic q_full;
  logic q_push;
  cmd_t q_in_cmd;
  cmd_t q_head_cmd;
  logic q_empty;
  logic q_pop;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_vertices      <= MAX_VERTICES_RST;
      cfg_r.max_triangles     <= MAX_TRIANGLES_RST;
      cfg_r.mesh_vertex_count <= MESH_VERTEX_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_VERTICES:      cfg_r.max_vertices      <= cfg_data[6:0];
        CFG_MAX_TRIANGLES:     cfg_r.max_triangles     <= cfg_data[7:0];
        CFG_MESH_VERTEX_COUNT: cfg_r.mesh_vertex_count <= cfg_data;
        default: ;
      endcase
    end
  end

  gmp_front #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .INDEX_BITS  (INDEX_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_func         (in_func),
    .in_first_index  (in_first_index),
    .in_second_index (in_second_index),
    .in_third_index  (in_third_index),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_cmd           (q_in_cmd)
  );

  gmp_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head_cmd (q_head_cmd),
    .empty    (q_empty)
  );

  gmp_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .head_cmd            (q_head_cmd),
    .q_empty             (q_empty),
    .q_pop               (q_pop),
    .out_kind            (out_kind),
    .out_global_vertex   (out_global_vertex),
    .out_packed_triangle (out_packed_triangle),
    .out_vertex_offset   (out_vertex_offset),
    .out_vertex_count    (out_vertex_count),
    .out_triangle_offset (out_triangle_offset),
    .out_triangle_count  (out_triangle_count),
    .out_last            (out_last),
    .out_empty           (out_empty),
    .out_pop             (out_pop)
  );

endmodule
